[rtl/fsbc_pkg.sv]
// fsbc_pkg: shared types and constants for the false slot byte cipher
// no dependencies; imported by false_slot_byte_cipher
package fsbc_pkg;

   localparam int MAX_KEY_BYTES = 8;
   localparam int KEY_W         = 64;
   localparam int LEN_W         = 4;
   localparam int IDX_W         = 3;
   localparam int CSR_IDX_W     = 2;

   localparam logic [7:0] MASK_REAL  = 8'b0000_0000;
   localparam logic [7:0] MASK_DECOY = 8'b1111_1111;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_MODE       = 2'd0,
      CFG_KEY        = 2'd1,
      CFG_KEY_LENGTH = 2'd2
   } cfg_index_type;

   typedef enum logic {
      MODE_EMBED = 1'b0,
      MODE_STRIP = 1'b1
   } mode_type;

   typedef struct packed {
      logic [7:0] out_a;
      logic [7:0] out_b;
      logic       keep;
      logic       last;
   } rsp_word_type;

endpackage

[rtl/false_slot_byte_cipher.sv]
// false_slot_byte_cipher: decoy slot byte cipher, one slot word in, one word out
// depends on fsbc_pkg
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------------
//   req     | in  | req_valid/req_stall | first, is_real, byte_a, byte_b, last_in
//   rsp     | out | rsp_valid/rsp_stall | out_a, out_b, keep, last
//   csr     | in  | csr_we              | csr_index, csr_wdata
//
// one word per cycle sustained while rsp_stall is low; a taken word is registered in
// the result register or, under rsp stall, the skid; the slot logic sits between the
// request ports and the result register; key copy rotation and slot index step update in the same cycle
// a skid register behind the result register keeps req flowing under one rsp stall;
// req_stall rises only when both are full
// synchronous active-high reset: mode embed, key 0, key length 8, key copy 0
module false_slot_byte_cipher (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_first,
   input  logic                               req_is_real,
   input  logic [7:0]                         req_byte_a,
   input  logic [7:0]                         req_byte_b,
   input  logic                               req_last_in,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_a,
   output logic [7:0]                         rsp_out_b,
   output logic                               rsp_keep,
   output logic                               rsp_last,
   // configuration writes
   input  logic                               csr_we,
   input  logic [fsbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fsbc_pkg::KEY_W-1:0]         csr_wdata
);
   import fsbc_pkg::*;

   // configuration registers
   mode_type           mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [LEN_W-1:0]   key_length_ff;

   // message state
   logic [KEY_W-1:0]   key_stream_ff, key_stream_in;
   logic [IDX_W-1:0]   slot_idx_ff, slot_idx_in;

   // result register and skid
   rsp_word_type       rsp_ff, skid_ff, word_in;
   logic               rsp_valid_ff, skid_valid_ff;

   logic               req_take, rsp_take;

   // slot datapath
   logic [LEN_W-1:0]   eff_len;
   logic [KEY_W-1:0]   amask;
   logic [KEY_W-1:0]   stream_cur;
   logic [IDX_W-1:0]   idx_cur;
   logic [LEN_W-1:0]   idx_step;
   logic               top;
   logic [2:0]         bit_sel;
   logic [7:0]         key_byte;
   logic [7:0]         mask;
   logic [KEY_W-1:0]   rotated;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------
   // configuration port, unknown index ignored
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_EMBED;
         key_ff        <= '0;
         key_length_ff <= LEN_W'(MAX_KEY_BYTES);
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_MODE:       mode_ff       <= mode_type'(csr_wdata[0]);
            CFG_KEY:        key_ff        <= csr_wdata;
            CFG_KEY_LENGTH: key_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // slot logic
   // ---------------------------------------------------------------
   always_comb begin
      // zero length acts as one, oversize clamps to the maximum
      if (key_length_ff == '0)
         eff_len = LEN_W'(1);
      else if (key_length_ff > LEN_W'(MAX_KEY_BYTES))
         eff_len = LEN_W'(MAX_KEY_BYTES);
      else
         eff_len = key_length_ff;

      // active bytes are the top eff_len bytes of the key word
      for (int k = 0; k < MAX_KEY_BYTES; k++)
         amask[8*(MAX_KEY_BYTES-1-k) +: 8] = (LEN_W'(k) < eff_len) ? 8'hFF : 8'h00;

      // first word reloads the key copy before the slot is handled
      stream_cur = req_first ? (key_ff & amask) : key_stream_ff;
      idx_cur    = req_first ? '0 : slot_idx_ff;
      // index past a shrunk length falls back to byte 0
      if ({1'b0, idx_cur} >= eff_len)
         idx_cur = '0;

      top      = stream_cur[KEY_W-1];
      // marker position is the low three bits of the top byte, counted
      // from the msb, so bit index is 7 - pos
      bit_sel  = ~stream_cur[KEY_W-8 +: 3];
      key_byte = key_ff[8*(MAX_KEY_BYTES-1-int'(idx_cur)) +: 8];

      word_in.last = req_last_in;
      if (mode_ff == MODE_EMBED) begin
         mask          = req_is_real ? MASK_REAL : MASK_DECOY;
         mask[bit_sel] = req_is_real ? top : ~top;
         word_in.out_a = req_byte_a ^ mask;
         word_in.out_b = mask ^ key_byte;
         word_in.keep  = 1'b1;
      end else begin
         mask          = req_byte_b ^ key_byte;
         word_in.out_a = req_byte_a ^ mask;
         word_in.out_b = mask;
         word_in.keep  = (mask[bit_sel] == top);
      end

      // rotate the active part left by one, top bit lands in its lowest bit
      rotated = {stream_cur[KEY_W-2:0], 1'b0} & amask;
      for (int k = 0; k < MAX_KEY_BYTES; k++)
         if (LEN_W'(k + 1) == eff_len)
            rotated[8*(MAX_KEY_BYTES-1-k)] = top;
      key_stream_in = rotated;

      idx_step    = {1'b0, idx_cur} + LEN_W'(1);
      slot_idx_in = (idx_step >= eff_len) ? '0 : idx_step[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_stream_ff <= '0;
         slot_idx_ff   <= '0;
      end else if (req_take) begin
         key_stream_ff <= key_stream_in;
         slot_idx_ff   <= slot_idx_in;
      end
   end

   // ---------------------------------------------------------------
   // result register with skid
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // req is stalled here, only draining happens
         if (rsp_take)
            skid_valid_ff <= 1'b0;
      end else if (req_take) begin
         if (rsp_valid_ff && !rsp_take)
            skid_valid_ff <= 1'b1;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take)
            rsp_ff <= skid_ff;
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take)
            rsp_ff <= word_in;
         else
            skid_ff <= word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_a = rsp_ff.out_a;
   assign rsp_out_b = rsp_ff.out_b;
   assign rsp_keep  = rsp_ff.keep;
   assign rsp_last  = rsp_ff.last;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // skid only fills behind a held result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without result word");

   // a first word restarts the slot index
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      req_take && req_first |=>
         slot_idx_ff == ((($past(eff_len)) > LEN_W'(1)) ? IDX_W'(1) : IDX_W'(0)))
      else $error("slot index not restarted by first word");

   // index stays inside the key length it was stepped with
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      req_take |=> {1'b0, slot_idx_ff} < $past(eff_len))
      else $error("slot index beyond key length");

   // rotation never leaves bits below the active bytes
   a_stream_masked: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (key_stream_ff & ~$past(amask)) == '0)
      else $error("key copy has bits outside active bytes");

endmodule
